// ----- hdl/skhte_pkg.sv -----
// package for the string key hash table engine
// holds shared widths, default sizes, operation and status codes, and the
// command and status structs between controller and datapath
`timescale 1ns / 1ps

package skhte_pkg;

    localparam int unsigned SLOTS_DEF     = 101;
    localparam int unsigned PROBES_DEF    = 20;
    localparam int unsigned KEY_BYTES_DEF = 8;

    localparam int unsigned HASH_MUL  = 19;
    localparam int unsigned HASH_MOD  = 101;
    localparam int unsigned PROBE_LIN = 23;

    localparam int unsigned ACT_W   = 2;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned HASH_W  = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD,
        ACT_DEL,
        ACT_FIND,
        ACT_READ
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_ADDED,
        STAT_PRESENT,
        STAT_NO_FREE,
        STAT_DELETED,
        STAT_NOT_FOUND,
        STAT_FOUND,
        STAT_READ
    } t_status;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic hash_step;
        logic probe_init;
        logic probe_issue;
        logic rd_issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic req_read;
        logic hash_last;
        logic probe_last;
        logic clear_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/skhte_ctrl.sv -----
// controller state machine for the hash table engine
// sequences clear pass, hashing, probing and result write-back
// depends on skhte_pkg
`timescale 1ns / 1ps

module skhte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  skhte_pkg::t_stat i_stat,
    output skhte_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PINIT,
        S_PROBE,
        S_DRAIN,
        S_RDREQ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    assign o_ready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.req_read ? S_RDREQ : S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe_issue = 1'b1;
                if (i_stat.probe_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_RDREQ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ----- hdl/skhte_dpath.sv -----
// datapath of the hash table engine: key hashing, probe address generation,
// slot memory with registered read, probe compare and result register
// depends on skhte_pkg
`timescale 1ns / 1ps

module skhte_dpath #(
    parameter int unsigned SLOTS     = skhte_pkg::SLOTS_DEF,
    parameter int unsigned PROBES    = skhte_pkg::PROBES_DEF,
    parameter int unsigned KEY_BYTES = skhte_pkg::KEY_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  skhte_pkg::t_cmd                     i_cmd,
    output skhte_pkg::t_stat                    o_stat,
    input  logic [skhte_pkg::ACT_W-1:0]         i_action,
    input  logic [skhte_pkg::KEY_W-1:0]         i_key_bytes,
    input  logic [skhte_pkg::SLOT_W-1:0]        i_slot_index,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [skhte_pkg::STAT_W-1:0]        o_status,
    output logic [skhte_pkg::SLOT_W-1:0]        o_slot,
    output logic                                o_slot_in_use,
    output logic [skhte_pkg::KEY_W-1:0]         o_slot_key,
    output logic [skhte_pkg::COUNT_W-1:0]       o_key_count
);

    localparam int unsigned KW  = skhte_pkg::KEY_W;
    localparam int unsigned HW  = skhte_pkg::HASH_W;
    localparam int unsigned HM  = skhte_pkg::HASH_MOD;
    localparam int unsigned SW  = $clog2(SLOTS);
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned PW  = $clog2(PROBES + 1);
    localparam int unsigned BW  = $clog2(KEY_BYTES + 1);
    localparam int unsigned XW  = (SW > skhte_pkg::SLOT_W) ? SW : skhte_pkg::SLOT_W;
    localparam int unsigned HKEY_SHIFT = 8 * (8 - KEY_BYTES);

    localparam logic [KW-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KW{1'b1}} :
        ((KW'(1) << (8 * KEY_BYTES)) - KW'(1));
    localparam logic [SW:0]   SLOTS_X = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0] D_INIT  = SW'((skhte_pkg::PROBE_LIN + 1) % SLOTS);
    localparam logic [SW-1:0] D_STEP  = SW'(2 % SLOTS);
    localparam logic [7:0]    HM_X    = 8'(HM);

    // constant tables
    logic [HW-1:0] byte_mod  [256];
    logic [HW-1:0] hash_fin  [HM];
    logic [SW-1:0] hash_slot [HM];

    for (genvar g = 0; g < 256; g++) begin : g_byte_mod
        assign byte_mod[g] = HW'(g % skhte_pkg::HASH_MOD);
    end
    for (genvar g = 0; g < HM; g++) begin : g_hash_tab
        assign hash_fin[g]  = HW'((g * skhte_pkg::HASH_MUL) % skhte_pkg::HASH_MOD);
        assign hash_slot[g] = SW'(g % SLOTS);
    end

    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SLOTS_X) begin
            sum = sum - SLOTS_X;
        end
        return sum[SW-1:0];
    endfunction

    // item registers
    skhte_pkg::t_action r_action;
    logic [KW-1:0]      r_key;
    logic [skhte_pkg::SLOT_W-1:0] r_idx;
    logic               r_idx_ok;

    // hashing
    logic [KW-1:0] r_hkey;
    logic [BW-1:0] r_bcnt;
    logic [HW-1:0] r_s;
    logic [HW-1:0] r_t;
    logic [7:0]    s_sum;
    logic [7:0]    t_sum;
    logic [HW-1:0] s_red;
    logic [HW-1:0] t_red;

    // probing
    logic [SW-1:0] r_p;
    logic [SW-1:0] r_d;
    logic [PW-1:0] r_jcnt;
    logic          r_live;
    logic [SW-1:0] r_qslot;
    logic          r_hit;
    logic [SW-1:0] r_hit_slot;
    logic          r_free;
    logic [SW-1:0] r_free_slot;

    // slot memory, mark in the top bit
    logic [KW:0]   mem [SLOTS];
    logic [KW:0]   r_q;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [KW:0]   wr_data;

    logic [SW-1:0] r_clr;
    logic [CW-1:0] r_count;

    // result
    logic          fin_wr;
    logic          fin_mark;
    logic [SW-1:0] fin_slot;
    logic [CW-1:0] n_count;
    skhte_pkg::t_status n_status;
    logic [skhte_pkg::SLOT_W-1:0] n_slot;
    logic          n_in_use;
    logic [KW-1:0] n_skey;
    logic          r_o_valid;

    assign o_stat.req_read   = (skhte_pkg::t_action'(i_action) == skhte_pkg::ACT_READ);
    assign o_stat.hash_last  = (r_bcnt == BW'(1));
    assign o_stat.probe_last = (r_jcnt == PW'(PROBES - 1));
    assign o_stat.clear_last = (r_clr == SW'(SLOTS - 1));
    assign o_stat.out_free   = !r_o_valid || i_ready;
    assign o_valid           = r_o_valid;

    always_comb begin
        s_sum = {1'b0, r_s} + {1'b0, byte_mod[r_hkey[KW-1 -: 8]]};
        s_red = (s_sum >= HM_X) ? HW'(s_sum - HM_X) : HW'(s_sum);
        t_sum = {1'b0, r_t} + {1'b0, s_red};
        t_red = (t_sum >= HM_X) ? HW'(t_sum - HM_X) : HW'(t_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= skhte_pkg::t_action'(i_action);
            r_key    <= i_key_bytes & KEY_MASK;
            r_hkey   <= (i_key_bytes & KEY_MASK) << HKEY_SHIFT;
            r_idx    <= i_slot_index;
            r_idx_ok <= (XW'(i_slot_index) < XW'(SLOTS));
            r_bcnt   <= BW'(KEY_BYTES);
            r_s      <= '0;
            r_t      <= '0;
        end else if (i_cmd.hash_step) begin
            r_hkey <= r_hkey << 8;
            r_bcnt <= r_bcnt - BW'(1);
            r_s    <= s_red;
            r_t    <= t_red;
        end
    end

    // probe address walk: step between probes grows by two each time
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_p    <= hash_slot[hash_fin[r_t]];
            r_d    <= D_INIT;
            r_jcnt <= '0;
        end else if (i_cmd.probe_issue) begin
            r_p    <= add_mod(r_p, r_d);
            r_d    <= add_mod(r_d, D_STEP);
            r_jcnt <= r_jcnt + PW'(1);
        end
        r_qslot <= r_p;
    end

    // compare of the probe read issued in the previous cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= i_cmd.probe_issue;
        end
        if (i_cmd.probe_init) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_live) begin
            if (r_q[KW] && (r_q[KW-1:0] == r_key) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_qslot;
            end
            if (!r_q[KW] && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_qslot;
            end
        end
    end

    always_comb begin
        fin_wr   = 1'b0;
        fin_mark = 1'b0;
        fin_slot = r_hit_slot;
        n_count  = r_count;
        n_status = skhte_pkg::STAT_NOT_FOUND;
        n_slot   = '0;
        n_in_use = 1'b0;
        n_skey   = '0;
        case (r_action)
            skhte_pkg::ACT_ADD: begin
                if (r_hit) begin
                    n_status = skhte_pkg::STAT_PRESENT;
                    n_slot   = skhte_pkg::SLOT_W'(r_hit_slot);
                end else if (r_free) begin
                    fin_wr   = 1'b1;
                    fin_mark = 1'b1;
                    fin_slot = r_free_slot;
                    n_count  = r_count + CW'(1);
                    n_status = skhte_pkg::STAT_ADDED;
                    n_slot   = skhte_pkg::SLOT_W'(r_free_slot);
                end else begin
                    n_status = skhte_pkg::STAT_NO_FREE;
                end
            end
            skhte_pkg::ACT_DEL: begin
                if (r_hit) begin
                    fin_wr   = 1'b1;
                    n_count  = r_count - CW'(1);
                    n_status = skhte_pkg::STAT_DELETED;
                    n_slot   = skhte_pkg::SLOT_W'(r_hit_slot);
                end
            end
            skhte_pkg::ACT_FIND: begin
                if (r_hit) begin
                    n_status = skhte_pkg::STAT_FOUND;
                    n_slot   = skhte_pkg::SLOT_W'(r_hit_slot);
                end
            end
            skhte_pkg::ACT_READ: begin
                n_status = skhte_pkg::STAT_READ;
                n_slot   = r_idx;
                if (r_idx_ok && r_q[KW]) begin
                    n_in_use = 1'b1;
                    n_skey   = r_q[KW-1:0];
                end
            end
            default: begin
                n_status = skhte_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        rd_en   = i_cmd.probe_issue || (i_cmd.rd_issue && r_idx_ok);
        rd_addr = i_cmd.probe_issue ? r_p : SW'(r_idx);
        wr_en   = i_cmd.clear_wr || (i_cmd.finish && fin_wr);
        wr_addr = i_cmd.clear_wr ? r_clr : fin_slot;
        wr_data = i_cmd.clear_wr ? '0 : {fin_mark, r_key};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.finish) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status      <= n_status;
            o_slot        <= n_slot;
            o_slot_in_use <= n_in_use;
            o_slot_key    <= n_skey;
            o_key_count   <= skhte_pkg::COUNT_W'(n_count);
        end
    end

endmodule

// ----- hdl/string_key_hash_table_engine.sv -----
// string key hash table engine: add, delete, look up and slot read
// add, delete and look up hash the key, then probe the slot memory, then register the result;
// one key byte hashed and one slot read per cycle; read slot reads the indexed slot directly
// one transaction in flight; ready returns in the same cycle that the result becomes valid
// after reset a clearing pass over the slot memory runs with ready low
`timescale 1ns / 1ps

module string_key_hash_table_engine #(
    parameter int unsigned SLOTS     = skhte_pkg::SLOTS_DEF,
    parameter int unsigned PROBES    = skhte_pkg::PROBES_DEF,
    parameter int unsigned KEY_BYTES = skhte_pkg::KEY_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [skhte_pkg::ACT_W-1:0]     i_action,
    input  logic [skhte_pkg::KEY_W-1:0]     i_key_bytes,
    input  logic [skhte_pkg::SLOT_W-1:0]    i_slot_index,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [skhte_pkg::STAT_W-1:0]    o_status,
    output logic [skhte_pkg::SLOT_W-1:0]    o_slot,
    output logic                            o_slot_in_use,
    output logic [skhte_pkg::KEY_W-1:0]     o_slot_key,
    output logic [skhte_pkg::COUNT_W-1:0]   o_key_count
);

    skhte_pkg::t_cmd  cmd;
    skhte_pkg::t_stat stat;

    skhte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    skhte_dpath #(
        .SLOTS     (SLOTS),
        .PROBES    (PROBES),
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_key_bytes   (i_key_bytes),
        .i_slot_index  (i_slot_index),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_slot_in_use (o_slot_in_use),
        .o_slot_key    (o_slot_key),
        .o_key_count   (o_key_count)
    );

endmodule

// ----- hdl/skhte_checker.sv -----
// port checker for the hash table engine, bound to the top level
// depends on skhte_pkg and string_key_hash_table_engine
`timescale 1ns / 1ps

module skhte_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [skhte_pkg::STAT_W-1:0]    o_status,
    input logic [skhte_pkg::SLOT_W-1:0]    o_slot,
    input logic                            o_slot_in_use,
    input logic [skhte_pkg::KEY_W-1:0]     o_slot_key,
    input logic [skhte_pkg::COUNT_W-1:0]   o_key_count
);

    // reset starts the clearing pass, no transaction taken right after
    a_reset_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input ready high right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_key_count))
        else $error("stalled result changed");

    a_read_fields_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != skhte_pkg::STAT_READ) |-> !o_slot_in_use && (o_slot_key == '0))
        else $error("slot contents on a non-read result");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == skhte_pkg::STAT_NO_FREE)
            || (o_status == skhte_pkg::STAT_NOT_FOUND)) |-> (o_slot == '0))
        else $error("nonzero slot on a miss");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |=> !o_valid || $past(o_valid) || !$past(o_ready))
        else $error("result appeared one cycle after idle ready");

endmodule

bind string_key_hash_table_engine skhte_checker u_skhte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_slot        (o_slot),
    .o_slot_in_use (o_slot_in_use),
    .o_slot_key    (o_slot_key),
    .o_key_count   (o_key_count)
);
